// ===== design/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define RCN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define RCN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/rcn_pkg.sv =====
// shared types and constants of the rc channel normalizer
package rcn_pkg;

  // channel layout
  localparam int NUM_CH   = 8;
  localparam int CH_IDX_W = $clog2(NUM_CH);
  localparam int RAW_W    = 13;
  localparam int NORM_W   = 14;
  localparam int LVL_W    = 7;

  localparam int CH_THR = 0;
  localparam int CH_AIL = 1;
  localparam int CH_ELE = 2;
  localparam int CH_RUD = 3;

  // beat layout
  localparam int IN_DATA_W  = NUM_CH * RAW_W;
  localparam int MONO_LSB   = NUM_CH * NORM_W;
  localparam int ACT_BIT    = MONO_LSB + NORM_W;
  localparam int LVL_LSB    = ACT_BIT + 1;
  localparam int OUT_USED_W = LVL_LSB + LVL_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // fixed values
  localparam logic [RAW_W-1:0]  MIDPOINT      = 13'd3750;
  localparam logic [LVL_W-1:0]  LEVEL_MAX     = 7'd100;
  localparam logic [3:0]        TRANS_CH_RST  = 4'd8;
  localparam logic [11:0]       THR_IDLE_RST  = 12'd50;
  localparam logic [7:0]        NOISE_THR_RST = 8'd5;
  localparam logic signed [14:0] TRANS_BIAS   = 15'sd1000;
  localparam logic [13:0]       LEVEL_ROUND   = 14'd10;

  // divide by 20 as multiply and shift, exact for 14-bit operands
  localparam int DIV20_SHIFT = 19;
  localparam int DIV20_MUL   = 26215;

  typedef logic [RAW_W-1:0]         raw_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REV_AIL   = 3'd0,
    REG_REV_ELE   = 3'd1,
    REG_REV_RUD   = 3'd2,
    REG_TRANS_CH  = 3'd3,
    REG_THR_IDLE  = 3'd4,
    REG_NOISE_THR = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        rev_ail;
    logic        rev_ele;
    logic        rev_rud;
    logic [3:0]  trans_ch;
    logic [11:0] thr_idle;
    logic [7:0]  noise_thr;
  } cfg_t;

endpackage

// ===== design/rcn_calib.sv =====
// calibration accumulators, frame counter and zero offset registers
module rcn_calib #(
  parameter int CAL_FRAMES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cal_en_i,
  input  rcn_pkg::raw_t [rcn_pkg::NUM_CH-1:0] raw_i,
  output rcn_pkg::raw_t [rcn_pkg::NUM_CH-1:0] offs_o,
  output logic                                done_o
);
  import rcn_pkg::*;

  localparam int L         = $clog2(CAL_FRAMES);
  localparam int CNT_W     = (L > 0) ? L : 1;
  localparam int SUM_W     = RAW_W + L;
  localparam int ROUND     = CAL_FRAMES / 2;
  localparam int DIV_SHIFT = SUM_W + L;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + CAL_FRAMES - 1) / CAL_FRAMES;
  localparam int MUL_W     = DIV_SHIFT - L + 2;
  localparam int PROD_W    = SUM_W + MUL_W;

  logic [SUM_W-1:0]  sums_q [NUM_CH];
  logic [SUM_W-1:0]  acc    [NUM_CH];
  logic [SUM_W-1:0]  rnd    [NUM_CH];
  logic [PROD_W-1:0] prod   [NUM_CH];
  raw_t              avg    [NUM_CH];
  raw_t              offs_q [NUM_CH];
  logic [CNT_W-1:0]  cnt_q;
  logic              last;

  // next sums and rounded averages, one lane per channel
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      acc[i]  = sums_q[i] + SUM_W'(raw_i[i]);
      rnd[i]  = acc[i] + SUM_W'(ROUND);
      prod[i] = PROD_W'(rnd[i]) * PROD_W'(DIV_MUL);
      avg[i]  = prod[i][DIV_SHIFT +: RAW_W];
    end
  end

  assign last   = (cnt_q == CNT_W'(CAL_FRAMES - 1));
  assign done_o = cal_en_i && last;

  // accumulate, or load offsets on the closing sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sums_q[i] <= '0;
        offs_q[i] <= MIDPOINT;
      end
    end else if (cal_en_i) begin
      if (last) begin
        cnt_q <= '0;
        for (int i = 0; i < NUM_CH; i++) begin
          sums_q[i] <= '0;
          offs_q[i] <= avg[i];
        end
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
        for (int i = 0; i < NUM_CH; i++) begin
          sums_q[i] <= acc[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      offs_o[i] = offs_q[i];
    end
  end

endmodule

// ===== design/rcn_norm.sv =====
// offset removal, stick activity detection and transition level
module rcn_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  rcn_pkg::cfg_t                        cfg_i,
  input  rcn_pkg::raw_t  [rcn_pkg::NUM_CH-1:0] raw_i,
  input  rcn_pkg::raw_t  [rcn_pkg::NUM_CH-1:0] offs_i,
  output rcn_pkg::norm_t [rcn_pkg::NUM_CH-1:0] norm_o,
  output rcn_pkg::norm_t                       mono_o,
  output logic                                 active_o,
  output logic [rcn_pkg::LVL_W-1:0]            level_o
);
  import rcn_pkg::*;

  norm_t                 delta [NUM_CH];
  norm_t [NUM_CH-1:0]    norm;
  logic signed [15:0]    stick_sum;
  logic signed [15:0]    prev_sum_q;
  logic signed [16:0]    sum_diff;
  logic signed [16:0]    noise_s;
  norm_t                 idle_s;
  norm_t                 sel;
  logic signed [14:0]    biased;
  logic [13:0]           lvl_in;
  logic [28:0]           lvl_prod;
  logic [9:0]            lvl_quot;

  // raw minus offset, bipolar throttle, stick reversal
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      delta[i] = $signed({1'b0, raw_i[i]}) - $signed({1'b0, offs_i[i]});
      norm[i]  = delta[i];
    end
    norm[CH_THR] = $signed({1'b0, raw_i[CH_THR]}) - $signed({1'b0, MIDPOINT});
    if (cfg_i.rev_ail) norm[CH_AIL] = -delta[CH_AIL];
    if (cfg_i.rev_ele) norm[CH_ELE] = -delta[CH_ELE];
    if (cfg_i.rev_rud) norm[CH_RUD] = -delta[CH_RUD];
  end

  // activity: stick sum moved beyond the noise band, or throttle above idle
  assign stick_sum = 16'(norm[CH_AIL]) + 16'(norm[CH_ELE]) + 16'(norm[CH_RUD]);
  assign sum_diff  = 17'(stick_sum) - 17'(prev_sum_q);
  assign noise_s   = $signed({9'b0, cfg_i.noise_thr});
  assign idle_s    = $signed({2'b0, cfg_i.thr_idle});
  assign active_o  = (sum_diff > noise_s) || (sum_diff < -noise_s) ||
                     (delta[CH_THR] > idle_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sum_q <= '0;
    end else if (en_i) begin
      prev_sum_q <= stick_sum;
    end
  end

  // transition level: (sel + 1000, floored at zero, + 10) / 20, capped
  always_comb begin
    if (cfg_i.trans_ch < 4'(NUM_CH)) begin
      sel = norm[cfg_i.trans_ch[CH_IDX_W-1:0]];
    end else begin
      sel = '0;
    end
    biased = 15'(sel) + TRANS_BIAS;
    if (biased < 0) begin
      lvl_in = LEVEL_ROUND;
    end else begin
      lvl_in = biased[13:0] + LEVEL_ROUND;
    end
    lvl_prod = 29'(lvl_in) * 29'(DIV20_MUL);
    lvl_quot = lvl_prod[DIV20_SHIFT +: 10];
    if (lvl_quot > 10'(LEVEL_MAX)) begin
      level_o = LEVEL_MAX;
    end else begin
      level_o = lvl_quot[LVL_W-1:0];
    end
  end

  assign norm_o = norm;
  assign mono_o = delta[CH_THR];

endmodule

// ===== design/rc_channel_normalizer.sv =====
// top level of the rc channel normalizer
//
// Usage: one radio frame per input beat on the s_axis channel, tuser set for a
// calibration sample and clear for a normal frame. Each input beat yields one
// output beat on the m_axis channel. A normal frame returns the offset-free
// channels, monopolar throttle, activity flag and transition level with tuser
// clear. A calibration frame returns all-zero data; its tuser is set on the
// frame that closes CAL_FRAMES samples, and that frame loads new zero offsets
// from the rounded averages.
// Throughput: one frame per cycle while the output is not stalled. A frame
// passes through the input register and then the result register; its offset,
// sum and average logic lies between the two.
// Reset: offsets return to 3750, the calibration sums, sample count and stored
// stick sum clear, the configuration registers take their defaults, and both
// channels come up empty.
// Stall: while m_axis_tready_i is low the result holds; one more frame can
// sit in the input register, after which s_axis_tready_o drops.
// Configuration writes through cfg_we_i take effect at the next clock edge and
// are meant to be issued while no frame is in flight.
module rc_channel_normalizer #(
  parameter int CAL_FRAMES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input frames
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // raw_throttle, raw_aileron, raw_elevator, raw_rudder,
  // raw_aux_a, raw_aux_b, raw_aux_c, raw_aux_d
  input  logic [rcn_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic                               s_axis_tuser_i,
  // results
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // norm_throttle, norm_aileron, norm_elevator, norm_rudder, norm_aux_a,
  // norm_aux_b, norm_aux_c, norm_aux_d, monopolar_throttle, rx_active,
  // transition_level, zero fill
  output logic [rcn_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // calibration_done
  output logic                               m_axis_tuser_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [rcn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcn_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rcn_pkg::*;

  cfg_t                  cfg_q;
  logic                  in_valid_q;
  logic                  in_action_q;
  logic [IN_DATA_W-1:0]  in_data_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_DATA_W-1:0] out_data_d;
  logic                  out_user_q;
  logic                  out_user_d;
  logic                  advance;
  logic                  in_take;
  raw_t  [NUM_CH-1:0]    raw;
  raw_t  [NUM_CH-1:0]    offs;
  norm_t [NUM_CH-1:0]    norm;
  norm_t                 mono;
  logic                  active;
  logic [LVL_W-1:0]      level;
  logic                  cal_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rev_ail   <= 1'b0;
      cfg_q.rev_ele   <= 1'b0;
      cfg_q.rev_rud   <= 1'b0;
      cfg_q.trans_ch  <= TRANS_CH_RST;
      cfg_q.thr_idle  <= THR_IDLE_RST;
      cfg_q.noise_thr <= NOISE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_REV_AIL:   cfg_q.rev_ail   <= cfg_data_i[0];
        REG_REV_ELE:   cfg_q.rev_ele   <= cfg_data_i[0];
        REG_REV_RUD:   cfg_q.rev_rud   <= cfg_data_i[0];
        REG_TRANS_CH:  cfg_q.trans_ch  <= cfg_data_i[3:0];
        REG_THR_IDLE:  cfg_q.thr_idle  <= cfg_data_i[11:0];
        REG_NOISE_THR: cfg_q.noise_thr <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: a frame moves on when the result register is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tuser_i;
      in_data_q   <= s_axis_tdata_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      raw[i] = in_data_q[i*RAW_W +: RAW_W];
    end
  end

  rcn_calib #(
    .CAL_FRAMES (CAL_FRAMES)
  ) u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cal_en_i (advance && in_action_q),
    .raw_i    (raw),
    .offs_o   (offs),
    .done_o   (cal_done)
  );

  rcn_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance && !in_action_q),
    .cfg_i    (cfg_q),
    .raw_i    (raw),
    .offs_i   (offs),
    .norm_o   (norm),
    .mono_o   (mono),
    .active_o (active),
    .level_o  (level)
  );

  // result beat: zero data on calibration frames
  always_comb begin
    out_data_d = '0;
    out_user_d = 1'b0;
    if (in_action_q) begin
      out_user_d = cal_done;
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_data_d[i*NORM_W +: NORM_W] = norm[i];
      end
      out_data_d[MONO_LSB +: NORM_W] = mono;
      out_data_d[ACT_BIT]            = active;
      out_data_d[LVL_LSB +: LVL_W]   = level;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== design/rcn_checker.sv =====
// port-level checks of the rc channel normalizer, bound to the top level
`include "assert_macros.svh"

module rcn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tready_i,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [rcn_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input logic                           m_tuser_i
);
  import rcn_pkg::*;

  // no result beat is offered in the cycle after reset is seen
  `RCN_ASSERT_ALWAYS(a_rst_no_valid, !rst_ni |=> !m_tvalid_i, "result valid after reset")

  // a stalled result beat keeps its payload
  `RCN_ASSERT(a_stall_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "stalled result changed")

  // an empty result register never blocks the input side
  `RCN_ASSERT(a_ready_when_empty, !m_tvalid_i |-> s_tready_i, "input stalled with empty output")

  // calibration beats with tuser set carry zero data
  `RCN_ASSERT(a_cal_zero, m_tvalid_i && m_tuser_i |-> m_tdata_i == '0, "calibration beat with data")

  // transition level stays within its range
  `RCN_ASSERT(a_level_range, m_tvalid_i |-> m_tdata_i[LVL_LSB +: LVL_W] <= LEVEL_MAX, "transition level out of range")

endmodule

bind rc_channel_normalizer rcn_checker u_rcn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
